@@ rtl/core/rrf_pkg.sv @@
// Shared types and constants for the rounded rectangle fill rasterizer.
// No dependencies; used by rounded_rect_fill_rasterizer_unit.
`default_nettype none

package rrf_pkg;

  // Register map, one 32-bit register every 4 bytes
  typedef enum logic [2:0] {
    REG_RECT_LEFT      = 3'd0,
    REG_RECT_TOP       = 3'd1,
    REG_RECT_WIDTH     = 3'd2,
    REG_RECT_HEIGHT    = 3'd3,
    REG_CORNER_RADIUS  = 3'd4,
    REG_FILL_COLOR     = 3'd5,
    REG_SURFACE_WIDTH  = 3'd6,
    REG_SURFACE_HEIGHT = 3'd7
  } cfg_reg_t;

  localparam int ADDR_W  = 5;
  localparam int COORD_W = 12;
  localparam int POS_W   = 13;
  localparam int RAD_W   = 11;
  localparam int SQ_W    = 2 * RAD_W;
  localparam int COLOR_W = 32;
  localparam int OUT_W   = 64;
  localparam int IN_W    = 8;

  localparam logic [POS_W-1:0] SURFACE_WIDTH_RST  = 13'd1024;
  localparam logic [POS_W-1:0] SURFACE_HEIGHT_RST = 13'd768;

  // Walk position taken from the counters
  typedef struct packed {
    logic               pix;
    logic               last;
    logic               busy;
    logic [COORD_W-1:0] xx;
    logic [COORD_W-1:0] yy;
  } pos_stage_t;

  // Corner distances and clipping
  typedef struct packed {
    logic               pix;
    logic               last;
    logic               busy;
    logic               corner;
    logic               on_surf;
    logic [RAD_W-1:0]   dx;
    logic [RAD_W-1:0]   dy;
    logic [RAD_W-1:0]   rad;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } dist_stage_t;

  // Squared distances
  typedef struct packed {
    logic               pix;
    logic               last;
    logic               busy;
    logic               corner;
    logic               on_surf;
    logic [SQ_W-1:0]    dxsq;
    logic [SQ_W-1:0]    dysq;
    logic [SQ_W-1:0]    rsq;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } sq_stage_t;

endpackage

`default_nettype wire

@@ rtl/core/rounded_rect_fill_rasterizer_unit.sv @@
// Rounded rectangle fill rasterizer: APB register file, raster walk counters
// and single-pass pixel logic into one result register. Depends on rrf_pkg.
// Latency: the result of an input transfer is presented on the next cycle,
// from one result register fed by the walk counters and the pixel logic.
// Throughput: one input transfer and one result per cycle; a stalled result
// holds the input through s_tready, with no bubble when m_tready stays high.
// Reset (rst, synchronous, active high) clears the walk, the result valid bit
// and the registers (surface size to 1024 x 768).
`default_nettype none

module rounded_rect_fill_rasterizer_unit #(
  parameter int MAX_DIM = 4096
) (
  input  wire                          clk,
  input  wire                          rst,
  // APB configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [rrf_pkg::ADDR_W-1:0]   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Input stream
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [rrf_pkg::IN_W-1:0]     s_tdata,   // [0] start_req, [7:1] zero
  // Result stream
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // [0] write_enable, [12:1] pixel_x, [24:13] pixel_y, [56:25] pixel_color,
  // [57] busy_res, [63:58] zero
  output logic [rrf_pkg::OUT_W-1:0]    m_tdata,
  output logic                         m_tlast    // last
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > 14) ? DIM_W : 14;
  localparam logic [CMP_W-1:0] MAX_DIM_V = CMP_W'(MAX_DIM);

  // Configuration registers
  logic [12:0] rect_left;
  logic [12:0] rect_top;
  logic [11:0] rect_width;
  logic [11:0] rect_height;
  logic [10:0] corner_radius;
  logic [31:0] fill_color;
  logic [12:0] surface_width;
  logic [12:0] surface_height;

  rrf_pkg::cfg_reg_t cfg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = rrf_pkg::cfg_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left      <= '0;
      rect_top       <= '0;
      rect_width     <= '0;
      rect_height    <= '0;
      corner_radius  <= '0;
      fill_color     <= '0;
      surface_width  <= rrf_pkg::SURFACE_WIDTH_RST;
      surface_height <= rrf_pkg::SURFACE_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        rrf_pkg::REG_RECT_LEFT:      rect_left      <= pwdata[12:0];
        rrf_pkg::REG_RECT_TOP:       rect_top       <= pwdata[12:0];
        rrf_pkg::REG_RECT_WIDTH:     rect_width     <= pwdata[11:0];
        rrf_pkg::REG_RECT_HEIGHT:    rect_height    <= pwdata[11:0];
        rrf_pkg::REG_CORNER_RADIUS:  corner_radius  <= pwdata[10:0];
        rrf_pkg::REG_FILL_COLOR:     fill_color     <= pwdata;
        rrf_pkg::REG_SURFACE_WIDTH:  surface_width  <= pwdata[12:0];
        rrf_pkg::REG_SURFACE_HEIGHT: surface_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_sel)
      rrf_pkg::REG_RECT_LEFT:      prdata = {19'd0, rect_left};
      rrf_pkg::REG_RECT_TOP:       prdata = {19'd0, rect_top};
      rrf_pkg::REG_RECT_WIDTH:     prdata = {20'd0, rect_width};
      rrf_pkg::REG_RECT_HEIGHT:    prdata = {20'd0, rect_height};
      rrf_pkg::REG_CORNER_RADIUS:  prdata = {21'd0, corner_radius};
      rrf_pkg::REG_FILL_COLOR:     prdata = fill_color;
      rrf_pkg::REG_SURFACE_WIDTH:  prdata = {19'd0, surface_width};
      rrf_pkg::REG_SURFACE_HEIGHT: prdata = {19'd0, surface_height};
      default:                     prdata = '0;
    endcase
  end

  // Flow control: accept when the result register is empty or moves on
  logic m_free;

  assign m_free   = !m_tvalid || m_tready;
  assign s_tready = m_free;

  // Walk counters
  logic [11:0] column_count, column_count_next;
  logic [11:0] row_count, row_count_next;
  logic        walking, walking_next;
  logic        in_xfer, start_req, walk_now;
  logic [11:0] xx_cur, yy_cur;
  rrf_pkg::pos_stage_t pos_px;

  assign in_xfer   = s_tvalid && s_tready;
  assign start_req = s_tdata[0];
  assign walk_now  = start_req || walking;
  assign xx_cur    = start_req ? '0 : column_count;
  assign yy_cur    = start_req ? '0 : row_count;

  // Advance the walk one box pixel per transfer
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    walking_next      = walking;
    pos_px            = '0;
    pos_px.xx         = xx_cur;
    pos_px.yy         = yy_cur;
    if (walk_now) begin
      if (xx_cur >= rect_width || yy_cur >= rect_height) begin
        // position left the box: end the walk with no write
        walking_next      = 1'b0;
        column_count_next = '0;
        row_count_next    = '0;
        pos_px.last       = 1'b1;
      end else begin
        pos_px.pix = 1'b1;
        if (xx_cur == rect_width - 12'd1 && yy_cur == rect_height - 12'd1) begin
          walking_next      = 1'b0;
          column_count_next = '0;
          row_count_next    = '0;
          pos_px.last       = 1'b1;
        end else if (xx_cur == rect_width - 12'd1) begin
          walking_next      = 1'b1;
          column_count_next = '0;
          row_count_next    = yy_cur + 12'd1;
        end else begin
          walking_next      = 1'b1;
          column_count_next = xx_cur + 12'd1;
          row_count_next    = yy_cur;
        end
        pos_px.busy = walking_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      walking      <= 1'b0;
    end else if (in_xfer) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      walking      <= walking_next;
    end
  end

  // Clamp radius, pick corner distances, clip to surface
  logic [10:0]       rad_w, rad_c;
  logic [11:0]       w_minus_r, h_minus_r;
  logic              left_c, right_c, top_c, bot_c;
  logic [11:0]       dx_full, dy_full;
  logic signed [13:0] sx, sy;
  logic [CMP_W-1:0]  sw_eff, sh_eff;
  rrf_pkg::dist_stage_t dist_px;

  always_comb begin
    rad_w = ({corner_radius, 1'b0} > {1'b0, rect_width}) ? rect_width[11:1] : corner_radius;
    rad_c = ({rad_w, 1'b0} > {1'b0, rect_height}) ? rect_height[11:1] : rad_w;
    w_minus_r = rect_width - {1'b0, rad_c};
    h_minus_r = rect_height - {1'b0, rad_c};
    left_c  = pos_px.xx < {1'b0, rad_c};
    right_c = pos_px.xx >= w_minus_r;
    top_c   = pos_px.yy < {1'b0, rad_c};
    bot_c   = pos_px.yy >= h_minus_r;
    // left corners take priority, as do top corners
    dx_full = left_c ? ({1'b0, rad_c} - pos_px.xx) : (pos_px.xx - w_minus_r + 12'd1);
    dy_full = top_c  ? ({1'b0, rad_c} - pos_px.yy) : (pos_px.yy - h_minus_r + 12'd1);

    sx = $signed({rect_left[12], rect_left}) + $signed({2'b00, pos_px.xx});
    sy = $signed({rect_top[12], rect_top}) + $signed({2'b00, pos_px.yy});
    sw_eff = (CMP_W'(surface_width) > MAX_DIM_V) ? MAX_DIM_V : CMP_W'(surface_width);
    sh_eff = (CMP_W'(surface_height) > MAX_DIM_V) ? MAX_DIM_V : CMP_W'(surface_height);

    dist_px         = '0;
    dist_px.pix     = pos_px.pix;
    dist_px.last    = pos_px.last;
    dist_px.busy    = pos_px.busy;
    dist_px.corner  = (left_c || right_c) && (top_c || bot_c);
    dist_px.on_surf = !sx[13] && !sy[13] &&
                      (CMP_W'(sx[12:0]) < sw_eff) && (CMP_W'(sy[12:0]) < sh_eff);
    dist_px.dx      = dx_full[10:0];
    dist_px.dy      = dy_full[10:0];
    dist_px.rad     = rad_c;
    dist_px.px      = sx[11:0];
    dist_px.py      = sy[11:0];
  end

  // Squares
  rrf_pkg::sq_stage_t sq_px;

  always_comb begin
    sq_px         = '0;
    sq_px.pix     = dist_px.pix;
    sq_px.last    = dist_px.last;
    sq_px.busy    = dist_px.busy;
    sq_px.corner  = dist_px.corner;
    sq_px.on_surf = dist_px.on_surf;
    sq_px.dxsq    = dist_px.dx * dist_px.dx;
    sq_px.dysq    = dist_px.dy * dist_px.dy;
    sq_px.rsq     = dist_px.rad * dist_px.rad;
    sq_px.px      = dist_px.px;
    sq_px.py      = dist_px.py;
  end

  // Circle test
  logic [rrf_pkg::SQ_W:0] dist_sum;
  logic                   wr_pix;

  assign dist_sum = {1'b0, sq_px.dxsq} + {1'b0, sq_px.dysq};
  assign wr_pix   = sq_px.pix && sq_px.on_surf &&
                    !(sq_px.corner && (dist_sum > {1'b0, sq_px.rsq}));

  // Result register; hold while the result side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_free) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tlast <= sq_px.last;
      m_tdata <= {6'd0, sq_px.busy,
                  wr_pix ? fill_color : 32'd0,
                  wr_pix ? sq_px.py : 12'd0,
                  wr_pix ? sq_px.px : 12'd0,
                  wr_pix};
    end
  end

`ifndef ASSERT_OFF
  // A finished walk never reports itself busy
  a_last_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[57])
    else $error("last result reports busy");

  // Without a write the coordinates and color are zero
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[56:1] == '0)
    else $error("non-write result carries payload");

  // Idle walk keeps the counters at the box origin
  a_idle_origin: assert property (@(posedge clk) disable iff (rst)
    !walking |-> column_count == '0 && row_count == '0)
    else $error("counters off origin while idle");
`endif

endmodule

`default_nettype wire

@@ tb/sv/rrf_checker.sv @@
`timescale 1ns / 1ps
// Result checker for rounded_rect_fill_rasterizer_unit: follows APB register
// writes, predicts one pixel result per input transfer and compares the result
// stream in order. Depends on rrf_pkg.
module rrf_checker #(
  parameter int MAX_DIM = 4096
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [rrf_pkg::ADDR_W-1:0]  paddr,
  input  wire  [31:0]                 pwdata,
  input  wire                         pready,
  input  wire                         s_tvalid,
  input  wire                         s_tready,
  input  wire  [rrf_pkg::IN_W-1:0]    s_tdata,   // [0] start_req, [7:1] zero
  input  wire                         m_tvalid,
  input  wire                         m_tready,
  // [0] write_enable, [12:1] pixel_x, [24:13] pixel_y, [56:25] pixel_color,
  // [57] busy_res, [63:58] zero
  input  wire  [rrf_pkg::OUT_W-1:0]   m_tdata,
  input  wire                         m_tlast,   // last
  output int                          err_count,
  output int                          pending
);

  typedef struct packed {
    logic                        we;
    logic [rrf_pkg::COORD_W-1:0] px;
    logic [rrf_pkg::COORD_W-1:0] py;
    logic [rrf_pkg::COLOR_W-1:0] color;
    logic                        last;
    logic                        busy;
  } pixel_t;

  // Register shadow
  logic [rrf_pkg::POS_W-1:0]   cfg_left;
  logic [rrf_pkg::POS_W-1:0]   cfg_top;
  logic [rrf_pkg::COORD_W-1:0] cfg_width;
  logic [rrf_pkg::COORD_W-1:0] cfg_height;
  logic [rrf_pkg::RAD_W-1:0]   cfg_radius;
  logic [rrf_pkg::COLOR_W-1:0] cfg_color;
  logic [rrf_pkg::POS_W-1:0]   cfg_sw;
  logic [rrf_pkg::POS_W-1:0]   cfg_sh;

  // Walk position and activity
  logic [rrf_pkg::COORD_W-1:0] col_cnt;
  logic [rrf_pkg::COORD_W-1:0] row_cnt;
  logic                        walking;

  pixel_t awaited_pixels[$];
  pixel_t got;
  pixel_t want;

  // Handle one box pixel of the walk and advance the position
  function automatic pixel_t rasterize_step(input logic start);
    pixel_t res;
    longint w, h, r, sw, sh, xx, yy, sx, sy, dx, dy;
    bit     corner;
    res = '0;
    if (start) begin
      col_cnt = '0;
      row_cnt = '0;
      walking = 1'b1;
    end
    if (!walking) return res;

    w  = cfg_width;
    h  = cfg_height;
    r  = cfg_radius;
    sw = cfg_sw;
    sh = cfg_sh;
    xx = col_cnt;
    yy = row_cnt;

    // Position lies outside the box (empty box, or box shrank mid walk)
    if (xx >= w || yy >= h) begin
      walking  = 1'b0;
      col_cnt  = '0;
      row_cnt  = '0;
      res.last = 1'b1;
      return res;
    end

    if (2 * r > w) r = w / 2;
    if (2 * r > h) r = h / 2;
    if (sw > MAX_DIM) sw = MAX_DIM;
    if (sh > MAX_DIM) sh = MAX_DIM;

    sx = longint'($signed(cfg_left)) + xx;
    sy = longint'($signed(cfg_top)) + yy;

    // Distances from the inner edge of whichever corner square holds the pixel
    corner = 1'b1;
    dx = 0;
    dy = 0;
    if (xx < r && yy < r) begin
      dx = r - xx;
      dy = r - yy;
    end else if (xx >= w - r && yy < r) begin
      dx = xx - (w - r - 1);
      dy = r - yy;
    end else if (xx < r && yy >= h - r) begin
      dx = r - xx;
      dy = yy - (h - r - 1);
    end else if (xx >= w - r && yy >= h - r) begin
      dx = xx - (w - r - 1);
      dy = yy - (h - r - 1);
    end else begin
      corner = 1'b0;
    end

    if (!(corner && dx * dx + dy * dy > r * r) &&
        sx >= 0 && sy >= 0 && sx < sw && sy < sh) begin
      res.we    = 1'b1;
      res.px    = sx[rrf_pkg::COORD_W-1:0];
      res.py    = sy[rrf_pkg::COORD_W-1:0];
      res.color = cfg_color;
    end

    if (xx == w - 1 && yy == h - 1) begin
      walking  = 1'b0;
      col_cnt  = '0;
      row_cnt  = '0;
      res.last = 1'b1;
    end else if (xx == w - 1) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    res.busy = walking;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_left   = '0;
      cfg_top    = '0;
      cfg_width  = '0;
      cfg_height = '0;
      cfg_radius = '0;
      cfg_color  = '0;
      cfg_sw     = rrf_pkg::SURFACE_WIDTH_RST;
      cfg_sh     = rrf_pkg::SURFACE_HEIGHT_RST;
      col_cnt    = '0;
      row_cnt    = '0;
      walking    = 1'b0;
      awaited_pixels.delete();
    end else begin
      // Predict from the registers as they stand before this edge
      if (s_tvalid && s_tready) awaited_pixels.push_back(rasterize_step(s_tdata[0]));

      // Compare the result transfer with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.we    = m_tdata[0];
        got.px    = m_tdata[12:1];
        got.py    = m_tdata[24:13];
        got.color = m_tdata[56:25];
        got.busy  = m_tdata[57];
        got.last  = m_tlast;
        if (awaited_pixels.size() == 0) begin
          if (err_count < 10)
            $display("[%0t] result with nothing pending: we=%0d x=%0d y=%0d",
                     $realtime, got.we, got.px, got.py,
                     " color=%h last=%0d busy=%0d", got.color, got.last, got.busy);
          err_count++;
        end else begin
          want = awaited_pixels.pop_front();
          if (got !== want) begin
            if (err_count < 10)
              $display("[%0t] pixel mismatch: want we=%0d x=%0d y=%0d color=%h",
                       $realtime, want.we, want.px, want.py, want.color,
                       " last=%0d busy=%0d, got we=%0d x=%0d y=%0d color=%h",
                       want.last, want.busy, got.we, got.px, got.py, got.color,
                       " last=%0d busy=%0d", got.last, got.busy);
            err_count++;
          end
        end
      end

      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (rrf_pkg::cfg_reg_t'(paddr[rrf_pkg::ADDR_W-1:2]))
          rrf_pkg::REG_RECT_LEFT:      cfg_left   = pwdata[rrf_pkg::POS_W-1:0];
          rrf_pkg::REG_RECT_TOP:       cfg_top    = pwdata[rrf_pkg::POS_W-1:0];
          rrf_pkg::REG_RECT_WIDTH:     cfg_width  = pwdata[rrf_pkg::COORD_W-1:0];
          rrf_pkg::REG_RECT_HEIGHT:    cfg_height = pwdata[rrf_pkg::COORD_W-1:0];
          rrf_pkg::REG_CORNER_RADIUS:  cfg_radius = pwdata[rrf_pkg::RAD_W-1:0];
          rrf_pkg::REG_FILL_COLOR:     cfg_color  = pwdata[rrf_pkg::COLOR_W-1:0];
          rrf_pkg::REG_SURFACE_WIDTH:  cfg_sw     = pwdata[rrf_pkg::POS_W-1:0];
          rrf_pkg::REG_SURFACE_HEIGHT: cfg_sh     = pwdata[rrf_pkg::POS_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= awaited_pixels.size();
  end

endmodule

@@ tb/sv/rounded_rect_fill_rasterizer_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the rounded_rect_fill_rasterizer_unit testbench: clock, reset, APB
// programming and input stream stimulus; rrf_checker does prediction and
// comparison. Depends on rrf_pkg, rrf_checker and the block.
module rounded_rect_fill_rasterizer_unit_tb;

  localparam int MAX_DIM      = 4096;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 12;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [rrf_pkg::ADDR_W-1:0]  paddr    = '0;
  logic [31:0]                 pwdata   = '0;
  wire  [31:0]                 prdata;
  wire                         pready;
  logic                        s_tvalid = 1'b0;
  wire                         s_tready;
  logic [rrf_pkg::IN_W-1:0]    s_tdata  = '0;   // [0] start_req, [7:1] zero
  wire                         m_tvalid;
  logic                        m_tready = 1'b0;
  // [0] write_enable, [12:1] pixel_x, [24:13] pixel_y, [56:25] pixel_color,
  // [57] busy_res, [63:58] zero
  wire  [rrf_pkg::OUT_W-1:0]   m_tdata;
  wire                         m_tlast;         // last

  int err_count;
  int pending;
  int items_sent;
  bit steady;

  rounded_rect_fill_rasterizer_unit #(.MAX_DIM(MAX_DIM)) dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  rrf_checker #(.MAX_DIM(MAX_DIM)) chk (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .err_count (err_count),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  // Stall the result side about a third of the time, except in steady stretches
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 33);
  end

  // Offer one input item after a random gap and hold it until the transfer
  task automatic send_item(input logic start);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(rrf_pkg::IN_W-1){1'b0}}, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic drain_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle; bits above the field are random
  task automatic write_reg(input rrf_pkg::cfg_reg_t idx, input logic [31:0] value,
                           input int fw);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rrf_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= (32'($urandom()) << fw) | value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_box(input logic [rrf_pkg::POS_W-1:0] left,
                             input logic [rrf_pkg::POS_W-1:0] top,
                             input logic [rrf_pkg::COORD_W-1:0] w,
                             input logic [rrf_pkg::COORD_W-1:0] h,
                             input logic [rrf_pkg::RAD_W-1:0] r,
                             input logic [rrf_pkg::COLOR_W-1:0] color,
                             input logic [rrf_pkg::POS_W-1:0] sw,
                             input logic [rrf_pkg::POS_W-1:0] sh);
    write_reg(rrf_pkg::REG_RECT_LEFT,      32'(left),  rrf_pkg::POS_W);
    write_reg(rrf_pkg::REG_RECT_TOP,       32'(top),   rrf_pkg::POS_W);
    write_reg(rrf_pkg::REG_RECT_WIDTH,     32'(w),     rrf_pkg::COORD_W);
    write_reg(rrf_pkg::REG_RECT_HEIGHT,    32'(h),     rrf_pkg::COORD_W);
    write_reg(rrf_pkg::REG_CORNER_RADIUS,  32'(r),     rrf_pkg::RAD_W);
    write_reg(rrf_pkg::REG_FILL_COLOR,     color,      rrf_pkg::COLOR_W);
    write_reg(rrf_pkg::REG_SURFACE_WIDTH,  32'(sw),    rrf_pkg::POS_W);
    write_reg(rrf_pkg::REG_SURFACE_HEIGHT, 32'(sh),    rrf_pkg::POS_W);
  endtask

  // Abort a hung run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int                          phase;
    int                          npix;
    int                          cut;
    int                          directed_cnt;
    logic [rrf_pkg::POS_W-1:0]   left, top, sw, sh;
    logic [rrf_pkg::COORD_W-1:0] w, h;
    logic [rrf_pkg::RAD_W-1:0]   r;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Idle tick, then a start on the empty box left by reset
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    drain_stream();

    // 3x3 box on the bottom surface edge, one column off the left, oversized
    // radius; restart in the middle of the walk
    program_box(13'h1FFF, 13'd4095, 12'd3, 12'd3, 11'd2047, 32'hFFFF_FFFF,
                13'd4096, 13'd4096);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    send_item(1'b1);
    repeat (8) send_item(1'b0);
    drain_stream();

    // Widest box at the right surface edge, then shrink it under the walk
    program_box(13'd4095, 13'd0, 12'd4095, 12'd1, 11'd0, 32'd0, 13'h1FFF, 13'd1);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    drain_stream();
    write_reg(rrf_pkg::REG_RECT_WIDTH, 32'd1, rrf_pkg::COORD_W);
    send_item(1'b0);
    drain_stream();

    // Tallest box at the most negative x on a zero-width surface, then shrink
    program_box(13'h1000, 13'd0, 12'd1, 12'd4095, 11'd0, 32'h5A5A_A5A5, 13'd0, 13'd4096);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    drain_stream();
    write_reg(rrf_pkg::REG_RECT_HEIGHT, 32'd2, rrf_pkg::COORD_W);
    send_item(1'b0);
    drain_stream();

    // Random boxes, mostly small and near the surface origin
    directed_cnt = items_sent;
    phase = 0;
    while (items_sent < directed_cnt + RANDOM_ITEMS) begin
      steady = (phase >= 4 && phase < 7);
      left = ($urandom_range(3) == 0) ? 13'($urandom()) : 13'($urandom_range(30)) - 13'd6;
      top  = ($urandom_range(3) == 0) ? 13'($urandom()) : 13'($urandom_range(30)) - 13'd6;
      w    = 12'($urandom_range(12));
      h    = 12'($urandom_range(12));
      r    = ($urandom_range(4) == 0) ? 11'($urandom()) : 11'($urandom_range(7));
      case ($urandom_range(5))
        0: begin
          sw = 13'd4096;
          sh = 13'd4096;
        end
        1: begin
          sw = 13'($urandom());
          sh = 13'($urandom());
        end
        2: begin
          sw = 13'($urandom_range(1));
          sh = 13'($urandom_range(1));
        end
        default: begin
          sw = 13'($urandom_range(1, 40));
          sh = 13'($urandom_range(1, 40));
        end
      endcase
      program_box(left, top, w, h, r, $urandom(), sw, sh);
      npix = int'(w) * int'(h);

      if (npix > 4 && $urandom_range(4) == 0) begin
        // Stop partway, resize the box under the walk, then run it out
        cut = $urandom_range(1, npix - 1);
        send_item(1'b1);
        repeat (cut - 1) send_item(1'b0);
        drain_stream();
        w = 12'($urandom_range(12));
        h = 12'($urandom_range(12));
        r = 11'($urandom_range(7));
        write_reg(rrf_pkg::REG_RECT_WIDTH,    32'(w), rrf_pkg::COORD_W);
        write_reg(rrf_pkg::REG_RECT_HEIGHT,   32'(h), rrf_pkg::COORD_W);
        write_reg(rrf_pkg::REG_CORNER_RADIUS, 32'(r), rrf_pkg::RAD_W);
        repeat (int'(w) * int'(h) + 1) send_item(1'b0);
      end else begin
        // Full walk with an occasional stray restart and trailing idle ticks
        send_item(1'b1);
        repeat (npix - 1) send_item($urandom_range(39) == 0);
        repeat ($urandom_range(2)) send_item(1'b0);
      end
      drain_stream();
      phase++;
    end

    steady = 1'b0;
    drain_stream();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ rounded_rect_fill_rasterizer_unit.f @@
rtl/core/rrf_pkg.sv
rtl/core/rounded_rect_fill_rasterizer_unit.sv
tb/sv/rrf_checker.sv
tb/sv/rounded_rect_fill_rasterizer_unit_tb.sv
